// ----- rtl/lbrm_pkg.sv -----
// Package for the longitude bin range matcher.
// Holds the sequencer state type, the operation codes, the comparison
// result struct and the fixed field widths. No dependencies.
package lbrm_pkg;

  localparam int unsigned EdgeW    = 32;
  localparam int unsigned PosW     = 9;
  localparam int unsigned OutIdxW  = 9;
  localparam int unsigned CountW   = 10;
  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 24;

  localparam logic [CountW-1:0] BinCountReset = 10'd512;
  localparam logic [CountW-1:0] BinCountMin   = 10'd2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } lbrm_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_DONE
  } lbrm_state_e;

  typedef struct packed {
    logic hit_first;
    logic hit_second;
  } lbrm_hit_t;

endpackage

// ----- rtl/lon_bin_range_match_clamped.sv -----
// Longitude bin range matcher: finds the bins of two bounds in a table of edges.
// A load writes its edge when it is taken. A query passes the prime, scan and done
// states before it reaches the output register; the scan covers k bins (1 to n - 1
// for n bins in use). One item at a time: a query holds the input until it leaves done,
// with one edge read per bin, and a result that cannot leave stalls the next transaction.
// Reset idles the sequencer, drops output valid and sets bin_count to 512; edges stay.
module lon_bin_range_match_clamped
  import lbrm_pkg::*;
#(
  parameter int unsigned MAX_BINS = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel: bin_count
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CountW-1:0]   cfg_data_i,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // edge_index [8:0], edge_value [40:9], bound_first [72:41],
  // bound_second [104:73], zeros above
  input  logic [InDataW-1:0]  s_axis_tdata,
  // op [0]
  input  logic                s_axis_tuser,
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // low_index [8:0], high_index [17:9], zeros above
  output logic [OutDataW-1:0] m_axis_tdata,
  // status [0]
  output logic                m_axis_tuser
);

  localparam int unsigned IdxW = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned CntW = $clog2(MAX_BINS + 1);

  // Input field unpacking
  logic [PosW-1:0]         in_pos;
  logic signed [EdgeW-1:0] in_edge;
  logic signed [EdgeW-1:0] in_b0;
  logic signed [EdgeW-1:0] in_b1;
  lbrm_op_e                in_op;

  assign in_pos  = s_axis_tdata[8:0];
  assign in_edge = s_axis_tdata[40:9];
  assign in_b0   = s_axis_tdata[72:41];
  assign in_b1   = s_axis_tdata[104:73];
  assign in_op   = lbrm_op_e'(s_axis_tuser);

  // Configuration
  logic [CountW-1:0] bin_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q <= BinCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bin_count_q <= cfg_data_i;
    end
  end

  // Effective bin count saturated to 2..MAX_BINS, and the last index
  logic [CntW-1:0] n_sat;
  logic [IdxW-1:0] last_idx;

  always_comb begin
    if (bin_count_q < BinCountMin) begin
      n_sat = CntW'(2);
    end else if (32'(bin_count_q) > 32'(MAX_BINS)) begin
      n_sat = CntW'(MAX_BINS);
    end else begin
      n_sat = CntW'(bin_count_q);
    end
    last_idx = IdxW'(n_sat - CntW'(1));
  end

  // Sequencer state and datapath registers
  lbrm_state_e             state_q, state_d;
  logic [IdxW-1:0]         i_q;
  logic signed [EdgeW-1:0] cur_q;
  logic signed [EdgeW-1:0] elast_q;
  logic signed [EdgeW-1:0] edge0_q;
  logic signed [EdgeW-1:0] b0_q, b1_q;
  logic                    f1_q, f2_q;
  logic [IdxW-1:0]         idx1_q, idx2_q;

  // Edge table
  logic signed [EdgeW-1:0] mem [MAX_BINS];
  logic signed [EdgeW-1:0] rd_q;
  logic                    rd_en;
  logic [IdxW-1:0]         rd_addr;
  logic                    wr_en;
  logic                    pos_ok;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[IdxW'(in_pos)] <= in_edge;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Scan step: bin i_q with edge[i_q] in cur_q and edge[i_q - 1] just read
  lbrm_hit_t hit;

  lbrm_step u_step (
    .bound_first_i  (b0_q),
    .bound_second_i (b1_q),
    .edge_low_i     (cur_q),
    .edge_high_i    (rd_q),
    .hit_o          (hit)
  );

  logic nf1, nf2, scan_end;

  assign nf1      = f1_q || hit.hit_first;
  assign nf2      = f2_q || hit.hit_second;
  assign scan_end = (nf1 && nf2) || (i_q == IdxW'(1));

  // Output register
  logic                m_valid_q;
  logic [OutIdxW-1:0]  m_low_q, m_high_q;
  logic                m_status_q;
  logic                out_free;

  assign out_free = !m_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && in_op == OP_QUERY) begin
          state_d = ST_PRIME;
        end
      end
      ST_PRIME: state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  assign pos_ok = 32'(in_pos) < 32'(MAX_BINS);

  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = last_idx;
    wr_en         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && in_op == OP_QUERY) begin
          rd_en   = 1'b1;
          rd_addr = last_idx;
        end
        if (s_axis_tvalid && in_op == OP_LOAD && pos_ok) begin
          wr_en = 1'b1;
        end
      end
      ST_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = i_q - IdxW'(1);
      end
      ST_SCAN: begin
        if (!scan_end) begin
          rd_en   = 1'b1;
          rd_addr = i_q - IdxW'(2);
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Clamping of unmatched bounds and ordering of the pair
  logic [IdxW-1:0] r1, r2, r_lo, r_hi;
  logic            r_fail;
  logic            b0_above, b1_above, b0_below, b1_below;

  always_comb begin
    b0_above = b0_q > edge0_q;
    b1_above = b1_q > edge0_q;
    b0_below = b0_q < elast_q;
    b1_below = b1_q < elast_q;
    r1       = idx1_q;
    r2       = idx2_q;
    r_fail   = 1'b0;
    priority if (!f1_q && !f2_q) begin
      if (b0_above && b1_above) begin
        r1 = '0;
        r2 = '0;
      end else if (b0_below && b1_below) begin
        r1 = last_idx;
        r2 = last_idx;
      end else begin
        r_fail = 1'b1;
      end
    end else if (!f2_q) begin
      if (b1_above) begin
        r2 = '0;
      end else if (b1_below) begin
        r2 = last_idx;
      end else begin
        r_fail = 1'b1;
      end
    end else if (!f1_q) begin
      if (b0_above) begin
        r1 = '0;
      end else if (b0_below) begin
        r1 = last_idx;
      end else begin
        r_fail = 1'b1;
      end
    end else begin
      r_fail = 1'b0;
    end
    r_lo = (r1 < r2) ? r1 : r2;
    r_hi = (r1 < r2) ? r2 : r1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && in_op == OP_LOAD && pos_ok && in_pos == '0) begin
          edge0_q <= in_edge;
        end
        if (s_axis_tvalid && in_op == OP_QUERY) begin
          b0_q <= in_b0;
          b1_q <= in_b1;
          i_q  <= last_idx;
          f1_q <= 1'b0;
          f2_q <= 1'b0;
        end
      end
      ST_PRIME: begin
        cur_q   <= rd_q;
        elast_q <= rd_q;
      end
      ST_SCAN: begin
        f1_q <= nf1;
        f2_q <= nf2;
        if (hit.hit_first) begin
          idx1_q <= i_q;
        end
        if (hit.hit_second) begin
          idx2_q <= i_q;
        end
        cur_q <= rd_q;
        i_q   <= i_q - IdxW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          m_low_q    <= r_fail ? '0 : OutIdxW'(r_lo);
          m_high_q   <= r_fail ? '0 : OutIdxW'(r_hi);
          m_status_q <= r_fail;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 2 * OutIdxW){1'b0}}, m_high_q, m_low_q};
  assign m_axis_tuser  = m_status_q;

endmodule

// ----- rtl/lbrm_step.sv -----
// One step of the bin scan: tests both bounds against one bin.
// A bin i holds a bound b when edge[i] <= b < edge[i-1].
// Depends on lbrm_pkg.
module lbrm_step
  import lbrm_pkg::*;
(
  input  logic signed [EdgeW-1:0] bound_first_i,
  input  logic signed [EdgeW-1:0] bound_second_i,
  input  logic signed [EdgeW-1:0] edge_low_i,
  input  logic signed [EdgeW-1:0] edge_high_i,
  output lbrm_hit_t               hit_o
);

  always_comb begin
    hit_o.hit_first  = (bound_first_i >= edge_low_i) && (bound_first_i < edge_high_i);
    hit_o.hit_second = (bound_second_i >= edge_low_i) && (bound_second_i < edge_high_i);
  end

endmodule

// ----- rtl/lbrm_checker.sv -----
// Port-level checker for the longitude bin range matcher, with its bind.
// Watches the result stream and the input handshake over time.
// Depends on lbrm_pkg and binds to lon_bin_range_match_clamped.
module lbrm_checker
  import lbrm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // An unplaced bound always reports both indices as zero.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[17:0] == 18'd0)
    else $error("failed query carries non-zero indices");

  // A placed pair is ordered.
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[8:0] <= m_axis_tdata[17:9])
    else $error("low index above high index");

  // Once a query is taken, the input ready drops.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY |=> !s_axis_tready)
    else $error("input accepted during a search");

endmodule

bind lon_bin_range_match_clamped lbrm_checker u_lbrm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- test/tb.sv -----
// Self-checking bench for the longitude bin range matcher.
// Loads edge tables, queries bin ranges and checks every result against its own
// prediction of the edge search. Depends on lbrm_pkg and the matcher RTL.
`timescale 1ns / 1ps

module tb;
  import lbrm_pkg::*;

  localparam int unsigned MaxBins     = 512;
  localparam int unsigned ItemsTarget = 1500;
  localparam int unsigned Settle      = 16;
  localparam int unsigned LongHold    = 400;
  localparam logic StatusPlaced   = 1'b0;
  localparam logic StatusUnplaced = 1'b1;

  typedef struct {
    lbrm_op_e           op;
    logic [PosW-1:0]    edge_index;
    logic signed [31:0] edge_value;
    logic signed [31:0] bound_a;
    logic signed [31:0] bound_b;
  } bin_item_t;

  typedef struct {
    logic [OutIdxW-1:0] low_idx;
    logic [OutIdxW-1:0] high_idx;
    logic               status;
  } bin_range_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CountW-1:0]   cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  lon_bin_range_match_clamped #(
    .MAX_BINS(MaxBins)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: what the block holds once each accepted transaction lands.
  logic signed [31:0] edge_mirror [MaxBins];
  logic [CountW-1:0]  bin_count_now = BinCountReset;
  // Generator view of the table, ahead of the block by the items still queued.
  logic signed [31:0] planned_edges [MaxBins];

  bin_item_t  pending_q [$];
  bin_range_t bin_range_q [$];
  bin_item_t  cur_item;
  bin_range_t want_r, got_r;
  bit         offering = 1'b0;
  bit         calm = 1'b0;
  bit         long_hold_req = 1'b0;
  bit         long_hold_done = 1'b0;
  int         long_hold_left = 0;
  int         in_gap = 0;
  int         out_gap = 0;
  int         items_planned = 0;
  int         loads_done = 0;
  int         queries_done = 0;
  int         results_seen = 0;
  int         unplaced_seen = 0;
  int         count_writes = 0;
  int         errors = 0;

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic int unsigned bins_in_use(logic [CountW-1:0] count_val);
    if (count_val < BinCountMin) return BinCountMin;
    if (count_val > MaxBins) return MaxBins;
    return count_val;
  endfunction

  // A bound that found no bin goes to 0 above edge 0, to the last index below
  // the last edge, and is unplaced otherwise.
  function automatic int clamp_outside(logic signed [31:0] bnd, int last_idx);
    if (bnd > edge_mirror[0]) return 0;
    if (bnd < edge_mirror[last_idx]) return last_idx;
    return -1;
  endfunction

  function automatic void locate_bins(logic signed [31:0] bnd_a, logic signed [31:0] bnd_b);
    int         last_idx;
    int         i;
    int         idx_a;
    int         idx_b;
    bin_range_t r;
    last_idx = bins_in_use(bin_count_now) - 1;
    idx_a = -1;
    idx_b = -1;
    for (i = last_idx; i > 0 && (idx_a < 0 || idx_b < 0); i--) begin
      if (bnd_a >= edge_mirror[i] && bnd_a < edge_mirror[i-1]) idx_a = i;
      if (bnd_b >= edge_mirror[i] && bnd_b < edge_mirror[i-1]) idx_b = i;
    end
    if (idx_a < 0 && idx_b < 0) begin
      if (bnd_a > edge_mirror[0] && bnd_b > edge_mirror[0]) begin
        idx_a = 0;
        idx_b = 0;
      end else if (bnd_a < edge_mirror[last_idx] && bnd_b < edge_mirror[last_idx]) begin
        idx_a = last_idx;
        idx_b = last_idx;
      end
    end else if (idx_b < 0) begin
      idx_b = clamp_outside(bnd_b, last_idx);
    end else if (idx_a < 0) begin
      idx_a = clamp_outside(bnd_a, last_idx);
    end
    if (idx_a < 0 || idx_b < 0) begin
      r.low_idx  = '0;
      r.high_idx = '0;
      r.status   = StatusUnplaced;
    end else begin
      r.low_idx  = OutIdxW'(idx_a < idx_b ? idx_a : idx_b);
      r.high_idx = OutIdxW'(idx_a < idx_b ? idx_b : idx_a);
      r.status   = StatusPlaced;
    end
    bin_range_q.push_back(r);
  endfunction

  function automatic void push_load(int unsigned pos, longint value);
    bin_item_t it;
    it.op         = OP_LOAD;
    it.edge_index = pos[PosW-1:0];
    it.edge_value = value[31:0];
    it.bound_a    = $urandom;
    it.bound_b    = $urandom;
    planned_edges[it.edge_index] = it.edge_value;
    pending_q.push_back(it);
    items_planned++;
  endfunction

  function automatic void push_query(logic signed [31:0] bnd_a, logic signed [31:0] bnd_b);
    bin_item_t it;
    it.op         = OP_QUERY;
    it.edge_index = PosW'($urandom);
    it.edge_value = $urandom;
    it.bound_a    = bnd_a;
    it.bound_b    = bnd_b;
    pending_q.push_back(it);
    items_planned++;
  endfunction

  // Bounds cluster on and around the edges of the planned table, with the
  // range ends and plain random values mixed in.
  function automatic logic signed [31:0] pick_bound(int unsigned n_eff);
    int unsigned k;
    longint      e_lo;
    longint      e_hi;
    longint      e_top;
    longint      e_end;
    k     = $urandom_range(1, n_eff - 1);
    e_lo  = planned_edges[k];
    e_hi  = planned_edges[k-1];
    e_top = planned_edges[0];
    e_end = planned_edges[n_eff-1];
    case ($urandom_range(0, 11))
      0: return 32'(e_lo);
      1: return 32'(e_lo - 1);
      2: return 32'(e_hi - 1);
      3: return 32'(e_top);
      4: return 32'(e_end);
      5: return 32'((e_top < 64'sd2147483647) ?
                    e_top + 1 + longint'($urandom) % (64'sd2147483647 - e_top) : e_top);
      6: return 32'((e_end > -64'sd2147483648) ?
                    e_end - 1 - longint'($urandom) % (e_end + 64'sd2147483648) : e_end);
      7: return 32'sh7fff_ffff;
      8: return 32'h8000_0000;
      9: return $urandom;
      default: return 32'((e_hi > e_lo) ? e_lo + longint'($urandom) % (e_hi - e_lo) : e_lo);
    endcase
  endfunction

  // Strictly descending edges with random steps, sometimes touching either
  // end of the signed range.
  function automatic void fill_descending(int unsigned n_eff);
    longint      step_sz [MaxBins];
    longint      total;
    longint      slack;
    longint      value;
    int unsigned max_step;
    int unsigned step_cap;
    int unsigned k;
    step_cap = 32'hffff_ffff / (n_eff - 1);
    case ($urandom_range(0, 3))
      0:       max_step = 3;
      1:       max_step = $urandom_range(4, 65536);
      default: max_step = step_cap;
    endcase
    if (max_step > step_cap) max_step = step_cap;
    total = 0;
    for (k = 1; k < n_eff; k++) begin
      step_sz[k] = $urandom_range(1, max_step);
      total += step_sz[k];
    end
    case ($urandom_range(0, 3))
      0:       slack = 0;
      1:       slack = 64'sd4294967295 - total;
      default: slack = longint'($urandom) % (64'sd4294967296 - total);
    endcase
    value = -64'sd2147483648 + total + slack;
    push_load(0, value);
    for (k = 1; k < n_eff; k++) begin
      value -= step_sz[k];
      push_load(k, value);
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i); while (pending_q.size() != 0 || offering || bin_range_q.size() != 0);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic write_bin_count(logic [CountW-1:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    bin_count_now = value;
    count_writes++;
    @(negedge clk_i);
  endtask

  task automatic run_phase(logic [CountW-1:0] count_val, bit refill, int n_queries,
                           bit with_noise);
    int unsigned n_eff;
    int unsigned pos;
    write_bin_count(count_val);
    n_eff = bins_in_use(count_val);
    if (refill) fill_descending(n_eff);
    if (with_noise) begin
      repeat ($urandom_range(1, 3)) begin
        pos = $urandom_range(1, n_eff - 1);
        case ($urandom_range(0, 2))
          0:       push_load(pos, planned_edges[pos-1]);
          1:       push_load(pos, $urandom);
          default: push_load($urandom_range(0, MaxBins - 1), $urandom);
        endcase
      end
    end
    repeat (n_queries) push_query(pick_bound(n_eff), pick_bound(n_eff));
  endtask

  // Input driver: one transaction offered at a time, with random idle bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (offering && s_axis_tready) begin
        if (cur_item.op == OP_LOAD) begin
          edge_mirror[cur_item.edge_index] = cur_item.edge_value;
          loads_done++;
        end else begin
          locate_bins(cur_item.bound_a, cur_item.bound_b);
          queries_done++;
        end
        offering = 1'b0;
      end
      if (offering) begin
        // Transaction still waiting for the block; hold everything.
      end else if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 3);
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_item = pending_q.pop_front();
        offering = 1'b1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, cur_item.bound_b, cur_item.bound_a,
                          cur_item.edge_value, cur_item.edge_index};
        s_axis_tuser  <= cur_item.op;
      end
    end
  end

  // One long receiver stall, started on request from the stimulus.
  always @(posedge clk_i) begin
    if (long_hold_req && !long_hold_done) begin
      long_hold_left <= LongHold;
      long_hold_done <= 1'b1;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.low_idx  = m_axis_tdata[OutIdxW-1:0];
        got_r.high_idx = m_axis_tdata[2*OutIdxW-1:OutIdxW];
        got_r.status   = m_axis_tuser;
        results_seen++;
        if (got_r.status == StatusUnplaced) unplaced_seen++;
        if (bin_range_q.size() == 0) begin
          flag_error($sformatf("unexpected result low %0d high %0d status %0d",
                               got_r.low_idx, got_r.high_idx, got_r.status));
        end else begin
          want_r = bin_range_q.pop_front();
          if (got_r.low_idx != want_r.low_idx || got_r.high_idx != want_r.high_idx ||
              got_r.status != want_r.status)
            flag_error($sformatf({"result %0d: expected low %0d high %0d status %0d, ",
                                  "got low %0d high %0d status %0d"},
                                 results_seen, want_r.low_idx, want_r.high_idx,
                                 want_r.status, got_r.low_idx, got_r.high_idx,
                                 got_r.status));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (long_hold_left == 0);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [CountW-1:0] count_val;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hand-made table with edges at 10, 0, -10 and -20 degrees.
    write_bin_count(10'd4);
    push_load(0, 655360);
    push_load(1, 0);
    push_load(2, -655360);
    push_load(3, -1310720);
    push_query(700000, 800000);              // both above the top edge
    push_query(-2000000, -1400000);          // both below the last edge
    push_query(700000, -2000000);            // outside on opposite sides
    push_query(655360, 0);                   // exactly on the top edge
    push_query(0, -1310720);
    push_query(-1, 1);
    push_query(32'sh7fff_ffff, -5);          // one clamps high
    push_query(32'h8000_0000, 100);          // one clamps low
    push_query(655359, 655359);
    push_query(-1310721, 5);
    push_load(2, 900000);                    // table no longer descending
    push_query(-5, 100);
    push_query(950000, 950000);
    push_query(655360, 655360);
    push_load(511, 32'sh7fff_ffff);
    push_load(510, 32'h8000_0000);
    write_bin_count(10'd0);
    push_query(1, -1);

    run_phase(10'd512, 1'b1, 20, 1'b0);
    wait_drained();
    long_hold_req = 1'b1;
    run_phase(10'd8, 1'b1, 30, 1'b0);
    run_phase(10'd1023, 1'b0, 8, 1'b1);
    run_phase(10'd1, 1'b1, 15, 1'b1);
    run_phase(10'd300, 1'b1, 10, 1'b0);
    run_phase(10'd2, 1'b1, 15, 1'b0);

    // Mostly small tables keep the scan short; large ones stay rare.
    while (items_planned < ItemsTarget) begin
      case ($urandom_range(0, 19))
        0: run_phase(CountW'($urandom_range(0, 1)), 1'b1, $urandom_range(8, 24),
                     1'($urandom_range(0, 1)));
        1: run_phase(10'd2, 1'b1, $urandom_range(8, 24), 1'b0);
        2: run_phase(CountW'($urandom_range(513, 1023)), 1'b0, 4, 1'b0);
        3: run_phase(CountW'($urandom_range(65, 200)), 1'b1, 6,
                     1'($urandom_range(0, 1)));
        default: begin
          count_val = CountW'($urandom_range(3, 40));
          run_phase(count_val, 1'b1, $urandom_range(8, 24), $urandom_range(0, 2) == 0);
        end
      endcase
    end

    // Closing stretch at full rate on both sides.
    wait_drained();
    calm = 1'b1;
    run_phase(10'd16, 1'b1, 25, 1'b1);
    run_phase(10'd5, 1'b1, 20, 1'b0);
    wait_drained();

    $display("Covered %0d edge loads and %0d queries over %0d bin_count writes.",
             loads_done, queries_done, count_writes);
    $display("Checked %0d results, %0d of them with an unplaced bound; %0d mismatches.",
             results_seen, unplaced_seen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
